[hw/rtl/aold_pkg.sv]
// ----------------------------------------------------------------------------
// aold_pkg
// Shared types and codes for the onset latency detector.
// ----------------------------------------------------------------------------
package aold_pkg;

    // Width of the fixed result and count fields.
    localparam int unsigned LEVEL_BITS   = 24;
    localparam int unsigned LATENCY_BITS = 32;
    localparam int unsigned COUNT_BITS   = 24;
    localparam int unsigned CHAN_BITS    = 3;

    // Reset value of the learn length register.
    localparam logic [COUNT_BITS-1:0] LEARN_SAMPLES_RESET = COUNT_BITS'(48000);

    // Input item codes.
    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_LEARN  = 2'd1,
        KIND_DETECT = 2'd2,
        KIND_CANCEL = 2'd3
    } kind_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_LEARN_DONE = 2'd0,
        ST_DETECTED   = 2'd1,
        ST_CANCELLED  = 2'd2,
        ST_REJECTED   = 2'd3
    } status_t;

endpackage

[hw/rtl/aold_ram.sv]
// ----------------------------------------------------------------------------
// aold_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module aold_ram #(
    parameter int unsigned WIDTH = 24,
    parameter int unsigned DEPTH = 8,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port; returns the old contents on a same-address write.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

[hw/rtl/audio_onset_latency_detector.sv]
// ----------------------------------------------------------------------------
// audio_onset_latency_detector
// Per-channel noise floor learning and onset latency counting on a stream
// of samples and commands.
// ----------------------------------------------------------------------------
//  channel   signals                              direction
//  input     in_valid, in_stall, kind, channel,   in  (stall out)
//            sample
//  result    out_valid, out_stall, status,        out (stall in)
//            latency, floor_level
//  config    learn_samples_we, learn_samples      in
//
// One item is taken per cycle while the input is not stalled. The floor memory is
// read at the input transfer edge and the second stage does the read-modify-write
// when it fires, which also loads the result register, so a result passes through
// the second stage and the result register; a same-channel write one item earlier
// is forwarded. Reset clears the control state and the per-channel valid bits, so
// an unwritten floor reads as 0.005 full scale. The input is stalled only while the
// second stage is full and the result register is stalled.
module audio_onset_latency_detector
    import aold_pkg::*;
#(
    parameter int unsigned NUM_CHANNELS = 8,
    parameter int unsigned SAMPLE_BITS  = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    kind,
    input  logic [CHAN_BITS-1:0]          channel,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    status,
    output logic [LATENCY_BITS-1:0]       latency,
    output logic [LEVEL_BITS-1:0]         floor_level,
    input  logic                          learn_samples_we,
    input  logic [COUNT_BITS-1:0]         learn_samples
);

    localparam int unsigned CH_AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [SAMPLE_BITS-1:0] FLOOR_RESET =
        SAMPLE_BITS'(((64'd1 << (SAMPLE_BITS - 1)) * 5) / 1000);
    localparam logic [COUNT_BITS-1:0]   COUNT_MAX   = '1;
    localparam logic [LATENCY_BITS-1:0] LATENCY_MAX = '1;

    // Configuration register.
    logic [COUNT_BITS-1:0] learn_samples_reg;

    // Control state.
    logic                    learn_active_reg,  learn_active_next;
    logic [CHAN_BITS-1:0]    learn_channel_reg, learn_channel_next;
    logic [COUNT_BITS-1:0]   learn_count_reg,   learn_count_next;
    logic                    detect_active_reg, detect_active_next;
    logic [CHAN_BITS-1:0]    detect_channel_reg, detect_channel_next;
    logic [LATENCY_BITS-1:0] detect_count_reg,  detect_count_next;
    logic [NUM_CHANNELS-1:0] vld_reg,           vld_next;

    // Second stage registers.
    logic                    s1_valid_reg;
    kind_t                   s1_kind_reg;
    logic [CHAN_BITS-1:0]    s1_chan_reg;
    logic                    s1_chan_ok_reg;
    logic [SAMPLE_BITS-1:0]  s1_mag_reg;
    logic                    s1_rd_ok_reg;
    logic                    s1_vld_reg;
    logic                    fwd_reg;
    logic [SAMPLE_BITS-1:0]  fwd_data_reg;

    // Result register.
    logic                    out_valid_reg;
    status_t                 status_reg;
    logic [LATENCY_BITS-1:0] latency_reg;
    logic [LEVEL_BITS-1:0]   floor_level_reg;

    logic                    accept;
    logic                    out_free;
    logic                    s1_fire;
    logic                    chan_ok;
    logic [SAMPLE_BITS-1:0]  mag;
    logic [CH_AW-1:0]        rd_addr;
    logic                    rd_ok;
    logic [SAMPLE_BITS-1:0]  ram_q;
    logic [SAMPLE_BITS-1:0]  cur_floor;
    logic [SAMPLE_BITS:0]    threshold;
    logic [SAMPLE_BITS-1:0]  new_floor;
    logic [COUNT_BITS-1:0]   learn_count_inc;
    logic                    wr_en;
    logic [CH_AW-1:0]        wr_addr;
    logic                    emit;
    status_t                 emit_status;
    logic [LATENCY_BITS-1:0] emit_latency;
    logic [SAMPLE_BITS-1:0]  emit_floor;

    // Handshake: the second stage moves on whenever the result slot is free.
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_fire  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign accept   = in_valid && !in_stall;

    // Input decode: channel range and sample magnitude.
    assign chan_ok = ({{(32 - CHAN_BITS){1'b0}}, channel} < NUM_CHANNELS);
    assign mag     = sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sample) : SAMPLE_BITS'(sample);

    // Read address: a cancel reads the channel of the mode it will end,
    // taken from the control state as it stands after the item ahead.
    always_comb
    begin
        rd_addr = CH_AW'(channel);
        rd_ok   = chan_ok;
        if (kind_t'(kind) == KIND_CANCEL)
        begin
            rd_ok = 1'b1;
            if (learn_active_next)
            begin
                rd_addr = CH_AW'(learn_channel_next);
            end
            else
            begin
                rd_addr = CH_AW'(detect_channel_next);
            end
        end
    end

    aold_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (NUM_CHANNELS)
    ) u_floor_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (new_floor),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    // Floor as seen by the item in the second stage.
    always_comb
    begin
        if (fwd_reg)
        begin
            cur_floor = fwd_data_reg;
        end
        else if (s1_vld_reg)
        begin
            cur_floor = ram_q;
        end
        else
        begin
            cur_floor = FLOOR_RESET;
        end
    end

    assign threshold       = {1'b0, cur_floor} + {3'b000, cur_floor[SAMPLE_BITS-1:2]};
    assign new_floor       = (s1_mag_reg > cur_floor) ? s1_mag_reg : cur_floor;
    assign learn_count_inc = (learn_count_reg != COUNT_MAX) ? learn_count_reg + 1'b1
                                                            : learn_count_reg;
    assign wr_addr         = CH_AW'(s1_chan_reg);

    // Second stage: mode control, floor update and result.
    always_comb
    begin
        learn_active_next   = learn_active_reg;
        learn_channel_next  = learn_channel_reg;
        learn_count_next    = learn_count_reg;
        detect_active_next  = detect_active_reg;
        detect_channel_next = detect_channel_reg;
        detect_count_next   = detect_count_reg;
        vld_next            = vld_reg;
        wr_en               = 1'b0;
        emit                = 1'b0;
        emit_status         = ST_LEARN_DONE;
        emit_latency        = '0;
        emit_floor          = cur_floor;

        if (s1_fire)
        begin
            case (s1_kind_reg)
                KIND_SAMPLE:
                begin
                    if (learn_active_reg)
                    begin
                        if (s1_chan_ok_reg && s1_chan_reg == learn_channel_reg)
                        begin
                            wr_en             = 1'b1;
                            vld_next[wr_addr] = 1'b1;
                            learn_count_next  = learn_count_inc;
                            if (learn_count_inc >= learn_samples_reg)
                            begin
                                learn_active_next = 1'b0;
                                emit              = 1'b1;
                                emit_status       = ST_LEARN_DONE;
                                emit_floor        = new_floor;
                            end
                        end
                    end
                    else if (detect_active_reg)
                    begin
                        if (s1_chan_ok_reg && s1_chan_reg == detect_channel_reg)
                        begin
                            if ({1'b0, s1_mag_reg} > threshold)
                            begin
                                detect_active_next = 1'b0;
                                emit               = 1'b1;
                                emit_status        = ST_DETECTED;
                                emit_latency       = detect_count_reg;
                            end
                            else if (detect_count_reg != LATENCY_MAX)
                            begin
                                detect_count_next = detect_count_reg + 1'b1;
                            end
                        end
                    end
                end
                KIND_LEARN:
                begin
                    if (learn_active_reg)
                    begin
                        emit        = 1'b1;
                        emit_status = ST_REJECTED;
                        emit_floor  = s1_rd_ok_reg ? cur_floor : '0;
                    end
                    else if (s1_chan_ok_reg)
                    begin
                        learn_active_next  = 1'b1;
                        learn_channel_next = s1_chan_reg;
                        learn_count_next   = '0;
                    end
                end
                KIND_DETECT:
                begin
                    if (s1_chan_ok_reg)
                    begin
                        detect_active_next  = 1'b1;
                        detect_channel_next = s1_chan_reg;
                        detect_count_next   = '0;
                    end
                end
                default:
                begin
                    if (learn_active_reg || detect_active_reg)
                    begin
                        learn_active_next  = 1'b0;
                        detect_active_next = 1'b0;
                        emit               = 1'b1;
                        emit_status        = ST_CANCELLED;
                    end
                end
            endcase
        end
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            learn_samples_reg <= LEARN_SAMPLES_RESET;
        end
        else if (learn_samples_we)
        begin
            learn_samples_reg <= learn_samples;
        end
    end

    // Control state and pipeline valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            learn_active_reg   <= 1'b0;
            learn_channel_reg  <= '0;
            learn_count_reg    <= '0;
            detect_active_reg  <= 1'b0;
            detect_channel_reg <= '0;
            detect_count_reg   <= '0;
            vld_reg            <= '0;
            s1_valid_reg       <= 1'b0;
            fwd_reg            <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            learn_active_reg   <= learn_active_next;
            learn_channel_reg  <= learn_channel_next;
            learn_count_reg    <= learn_count_next;
            detect_active_reg  <= detect_active_next;
            detect_channel_reg <= detect_channel_next;
            detect_count_reg   <= detect_count_next;
            vld_reg            <= vld_next;
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                fwd_reg      <= wr_en && (wr_addr == rd_addr);
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
                fwd_reg      <= 1'b0;
            end
            if (s1_fire)
            begin
                out_valid_reg <= emit;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Second stage payload, captured on each input transfer.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_kind_reg    <= kind_t'(kind);
            s1_chan_reg    <= channel;
            s1_chan_ok_reg <= chan_ok;
            s1_mag_reg     <= mag;
            s1_rd_ok_reg   <= rd_ok;
            s1_vld_reg     <= rd_ok && vld_reg[rd_addr];
            fwd_data_reg   <= new_floor;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (s1_fire && emit)
        begin
            status_reg      <= emit_status;
            latency_reg     <= emit_latency;
            floor_level_reg <= LEVEL_BITS'(emit_floor);
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign latency     = latency_reg;
    assign floor_level = floor_level_reg;

    // Only a detection carries a nonzero latency.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_DETECTED |-> latency == '0)
        else $error("latency set on a result other than a detection");

    // The input is stalled only while the second stage holds an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("input stalled with an empty second stage");

    // A forwarded floor always belongs to an item in the second stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        fwd_reg |-> s1_valid_reg)
        else $error("forwarded floor without an item");

    // A cancel that completes leaves both modes inactive.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_kind_reg == KIND_CANCEL |=> !learn_active_reg && !detect_active_reg)
        else $error("mode still active after a cancel");

endmodule
